// ===== design/rvp_pkg.sv =====
package rvp_pkg;

  localparam int ANGLE_BITS      = 10;
  localparam int COORD_FRAC_BITS = 12;

  localparam int QSTEPS  = 1 << (ANGLE_BITS - 2);
  localparam int SIN_ONE = 16384;

  // near limit arrives in Q12 and is moved to the coordinate format
  localparam int LIM_SHL = (COORD_FRAC_BITS >= 12) ? COORD_FRAC_BITS - 12 : 0;
  localparam int LIM_SHR = (COORD_FRAC_BITS < 12) ? 12 - COORD_FRAC_BITS : 0;
  localparam int LIM_W   = 13 + LIM_SHL;

  // projection depth (signed), divisor magnitude and dividend widths
  localparam int ZP_W   = (LIM_W + 1 > 17) ? LIM_W + 1 : 17;
  localparam int DMAG_W = ZP_W + 4;
  localparam int DIV_W  = DMAG_W + 1;
  localparam int NUM_W  = ((DMAG_W + 1 > 33) ? DMAG_W + 1 : 33) + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [1:0] {
    ACT_ROT_X = 2'd0,
    ACT_ROT_Y = 2'd1,
    ACT_ROT_Z = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_CENTER_X     = 2'd0,
    CFG_CENTER_Y     = 2'd1,
    CFG_FOCAL_LENGTH = 2'd2,
    CFG_NEAR_LIMIT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    action_e            action;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] vert_z;
    logic [9:0]         angle;
  } rvp_in_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [19:0] screen_x;
    logic signed [19:0] screen_y;
    logic               depth_clamped;
  } rvp_out_t;

  typedef struct packed {
    logic [11:0] center_x;
    logic [11:0] center_y;
    logic [15:0] focal_length;
    logic [12:0] near_limit;
  } rvp_cfg_t;

  // rotated vertex handed from front to back
  typedef struct packed {
    logic signed [15:0]     rot_x;
    logic signed [15:0]     rot_y;
    logic signed [15:0]     rot_z;
    logic signed [ZP_W-1:0] zp;
    logic                   clamped;
  } rvp_vtx_t;

  typedef logic [QSTEPS:0][14:0] sin_rom_t;

  function automatic logic [14:0] quarter_sin(int unsigned a);
    longint unsigned x, x2, u, w, y, r;
    x  = longint'(a) << (17 - ANGLE_BITS);
    x2 = (x * x) >> 15;
    u  = 64'd42047 - ((64'd4640 * x2) >> 15);
    w  = 64'd102944 - ((u * x2) >> 15);
    y  = (x * w) >> 15;
    r  = (y + 64'd2) >> 2;
    if (r > SIN_ONE) r = SIN_ONE;
    return r[14:0];
  endfunction

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t rom;
    for (int a = 0; a <= QSTEPS; a++) rom[a] = quarter_sin(a);
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

endpackage

// ===== design/rvp_front.sv =====
module rvp_front import rvp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rvp_in_t     in_data_i,
  input  logic [12:0] near_limit_i,
  output logic        push_o,
  output rvp_vtx_t    push_data_o,
  input  logic        full_i
);

  function automatic logic signed [15:0] sin_lookup(logic [ANGLE_BITS-1:0] p);
    logic [1:0]            quad;
    logic [ANGLE_BITS-3:0] r;
    logic [ANGLE_BITS-2:0] idx;
    logic signed [15:0]    mag;
    quad = p[ANGLE_BITS-1:ANGLE_BITS-2];
    r    = p[ANGLE_BITS-3:0];
    idx  = quad[0] ? (ANGLE_BITS-1)'(QSTEPS) - {1'b0, r} : {1'b0, r};
    mag  = signed'({1'b0, SIN_ROM[idx]});
    return quad[1] ? -mag : mag;
  endfunction

  function automatic logic signed [15:0] round_sat(logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [19:0] sh;
    t  = {v[32], v} + 34'sd8192;
    sh = t[33:14];
    if (sh > 20'sd32767) return 16'sh7fff;
    if (sh < -20'sd32768) return 16'sh8000;
    return sh[15:0];
  endfunction

  logic en;

  logic                  f1_v_q;
  action_e               act1_q;
  logic signed [15:0]    x1_q, y1_q, z1_q, s1_q, c1_q;
  logic [ANGLE_BITS-1:0] ang, ang_c;

  logic                  f2_v_q;
  action_e               act2_q;
  logic signed [15:0]    x2_q, y2_q, z2_q;
  logic signed [31:0]    p0_q, p1_q, p2_q, p3_q;
  logic signed [15:0]    a0, b0;

  logic                  f3_v_q;
  rvp_vtx_t              vtx_d, vtx_q;

  logic signed [32:0]    sum1, sum2;
  logic signed [15:0]    r1, r2, rz;
  logic [LIM_W-1:0]      lim;
  logic [16:0]           abs_z;

  assign en         = !(f3_v_q && full_i);
  assign in_ready_o = en;
  assign push_o     = f3_v_q && !full_i;
  assign push_data_o = vtx_q;

  assign ang   = in_data_i.angle[ANGLE_BITS-1:0];
  assign ang_c = ang + (ANGLE_BITS)'(QSTEPS);

  // operand pairs per axis: (a0, b0) = (y, z), (x, z) or (x, y)
  assign a0 = (act1_q == ACT_ROT_X) ? y1_q : x1_q;
  assign b0 = (act1_q == ACT_ROT_Z) ? y1_q : z1_q;

  always_comb begin
    if (act2_q == ACT_ROT_Y) begin
      sum1 = 33'(p0_q) + 33'(p1_q);
      sum2 = 33'(p3_q) - 33'(p2_q);
    end else begin
      sum1 = 33'(p0_q) - 33'(p1_q);
      sum2 = 33'(p2_q) + 33'(p3_q);
    end
    r1 = round_sat(sum1);
    r2 = round_sat(sum2);

    vtx_d.rot_x = x2_q;
    vtx_d.rot_y = y2_q;
    vtx_d.rot_z = z2_q;
    case (act2_q)
      ACT_ROT_X: begin
        vtx_d.rot_y = r1;
        vtx_d.rot_z = r2;
      end
      ACT_ROT_Y: begin
        vtx_d.rot_x = r1;
        vtx_d.rot_z = r2;
      end
      ACT_ROT_Z: begin
        vtx_d.rot_x = r1;
        vtx_d.rot_y = r2;
      end
      default: ;
    endcase

    // a zero limit is raised to one LSB so the divisor never vanishes
    lim = (LIM_W'(near_limit_i) << LIM_SHL) >> LIM_SHR;
    if (lim == '0) lim = LIM_W'(1);
    rz    = vtx_d.rot_z;
    abs_z = rz[15] ? 17'(-{rz[15], rz}) : 17'({rz[15], rz});
    vtx_d.clamped = 32'(abs_z) < 32'(lim);
    vtx_d.zp      = vtx_d.clamped ? ZP_W'(signed'({1'b0, lim})) : ZP_W'(rz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act1_q <= in_data_i.action;
      x1_q   <= in_data_i.vert_x;
      y1_q   <= in_data_i.vert_y;
      z1_q   <= in_data_i.vert_z;
      s1_q   <= sin_lookup(ang);
      c1_q   <= sin_lookup(ang_c);

      act2_q <= act1_q;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      z2_q   <= z1_q;
      p0_q   <= a0 * c1_q;
      p1_q   <= b0 * s1_q;
      p2_q   <= a0 * s1_q;
      p3_q   <= b0 * c1_q;

      vtx_q  <= vtx_d;
    end
  end

endmodule

// ===== design/rvp_fifo.sv =====
module rvp_fifo import rvp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rvp_vtx_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output rvp_vtx_t pop_data_o,
  output logic     empty_o
);

  rvp_vtx_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW:0] wr_q, rd_q;
  logic [FIFO_AW:0] fill;

  assign fill       = wr_q - rd_q;
  assign full_o     = fill == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o    = fill == '0;
  assign pop_data_o = mem_q[rd_q[FIFO_AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q[FIFO_AW-1:0]] <= push_data_i;
  end

endmodule

// ===== design/rvp_back.sv =====
module rvp_back import rvp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  output logic     pop_o,
  input  rvp_vtx_t pop_data_i,
  input  logic     empty_i,
  input  rvp_cfg_t cfg_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rvp_out_t out_data_o
);

  typedef struct packed {
    logic [NUM_W-1:0]   ax;
    logic [NUM_W-1:0]   ay;
    logic [DIV_W-1:0]   remx;
    logic [DIV_W-1:0]   remy;
    logic [DIV_W-1:0]   dv;
    logic               negx;
    logic               negy;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               clamped;
  } div_t;

  typedef struct packed {
    logic [NUM_W-1:0] a;
    logic [DIV_W-1:0] rem;
  } dstep_t;

  // one restoring step: shift in the next dividend bit, keep the quotient bit
  function automatic dstep_t div_step(logic [NUM_W-1:0] a, logic [DIV_W-1:0] rem,
                                      logic [DIV_W-1:0] dv);
    dstep_t          res;
    logic [DIV_W:0]  t;
    t = {rem, a[NUM_W-1]};
    if (t >= {1'b0, dv}) begin
      t       = t - {1'b0, dv};
      res.a   = {a[NUM_W-2:0], 1'b1};
    end else begin
      res.a   = {a[NUM_W-2:0], 1'b0};
    end
    res.rem = t[DIV_W-1:0];
    return res;
  endfunction

  function automatic logic signed [19:0] sat20(logic signed [NUM_W+1:0] v);
    if (v > (NUM_W+2)'(20'sh7ffff)) return 20'sh7ffff;
    if (v < (NUM_W+2)'(20'sh80000)) return 20'sh80000;
    return v[19:0];
  endfunction

  function automatic logic signed [19:0] place(logic [NUM_W-1:0] q, logic neg,
                                               logic [11:0] center);
    logic signed [NUM_W:0]   off;
    logic signed [NUM_W+1:0] sum;
    off = neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
    sum = (NUM_W+2)'(signed'({1'b0, center, 4'b0000})) + (NUM_W+2)'(off);
    return sat20(sum);
  endfunction

  logic en;

  logic                   b1_v_q;
  rvp_vtx_t               b1_q;

  logic                   b2_v_q;
  logic signed [32:0]     numx_q, numy_q;
  logic [DMAG_W-1:0]      dmag_q;
  logic                   zneg_q;
  rvp_vtx_t               b2_q;
  logic [ZP_W-1:0]        abs_zp;

  logic [31:0]            nmx, nmy;
  div_t                   st_d;
  div_t                   st_q   [NUM_W+1];
  div_t                   st_nxt [NUM_W];
  logic [NUM_W:0]         st_v_q;

  logic                   out_valid_q;
  rvp_out_t               out_q;
  rvp_out_t               out_d;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign abs_zp = b1_q.zp[ZP_W-1] ? ZP_W'(-b1_q.zp) : ZP_W'(b1_q.zp);

  always_comb begin
    nmx = numx_q[32] ? 32'(-numx_q) : numx_q[31:0];
    nmy = numy_q[32] ? 32'(-numy_q) : numy_q[31:0];
    // rounded quotient: (2n + d) / 2d
    st_d.ax      = NUM_W'({nmx, 1'b0}) + NUM_W'(dmag_q);
    st_d.ay      = NUM_W'({nmy, 1'b0}) + NUM_W'(dmag_q);
    st_d.remx    = '0;
    st_d.remy    = '0;
    st_d.dv      = {dmag_q, 1'b0};
    st_d.negx    = numx_q[32] ^ zneg_q;
    st_d.negy    = numy_q[32] ^ zneg_q;
    st_d.rot_x   = b2_q.rot_x;
    st_d.rot_y   = b2_q.rot_y;
    st_d.rot_z   = b2_q.rot_z;
    st_d.clamped = b2_q.clamped;
  end

  always_comb begin
    dstep_t sx, sy;
    for (int k = 0; k < NUM_W; k++) begin
      sx = div_step(st_q[k].ax, st_q[k].remx, st_q[k].dv);
      sy = div_step(st_q[k].ay, st_q[k].remy, st_q[k].dv);
      st_nxt[k]      = st_q[k];
      st_nxt[k].ax   = sx.a;
      st_nxt[k].remx = sx.rem;
      st_nxt[k].ay   = sy.a;
      st_nxt[k].remy = sy.rem;
    end
  end

  always_comb begin
    out_d.rot_x         = st_q[NUM_W].rot_x;
    out_d.rot_y         = st_q[NUM_W].rot_y;
    out_d.rot_z         = st_q[NUM_W].rot_z;
    out_d.depth_clamped = st_q[NUM_W].clamped;
    out_d.screen_x      = place(st_q[NUM_W].ax, st_q[NUM_W].negx, cfg_i.center_x);
    out_d.screen_y      = place(st_q[NUM_W].ay, st_q[NUM_W].negy, cfg_i.center_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q      <= 1'b0;
      b2_v_q      <= 1'b0;
      st_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b1_v_q      <= pop_o;
      b2_v_q      <= b1_v_q;
      st_v_q      <= {st_v_q[NUM_W-1:0], b2_v_q};
      out_valid_q <= st_v_q[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q   <= pop_data_i;
      b2_q   <= b1_q;
      numx_q <= b1_q.rot_x * signed'({1'b0, cfg_i.focal_length});
      numy_q <= b1_q.rot_y * signed'({1'b0, cfg_i.focal_length});
      dmag_q <= {abs_zp, 4'b0000};
      zneg_q <= b1_q.zp[ZP_W-1];
      st_q[0] <= st_d;
      for (int k = 0; k < NUM_W; k++) st_q[k+1] <= st_nxt[k];
      out_q  <= out_d;
    end
  end

endmodule

// ===== design/rotate_and_project_vertex.sv =====
// Rotates one vertex (signed Q3.12) about the x, y or z axis by a 1024-step
// angle, or passes it through, then projects it to the screen as
// center + x/z*focal and center + y/z*focal in signed Q15.4 pixels. Depths
// whose magnitude is below the near limit are replaced by +limit for the
// projection and flagged. One vertex is accepted per clock and one result word
// leaves per clock when nothing stalls. A word passes through 42 register
// stages: 3 rotation stages, one queue slot, 3 projection setup stages,
// 34 stages of the pipelined restoring divider at one quotient bit each,
// and the output register. A four-word queue between rotation and
// projection absorbs output stalls.
// Registers may change only while the block is idle: the user must ensure
// this, as the block itself does not enforce it.
module rotate_and_project_vertex import rvp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rvp_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rvp_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  rvp_cfg_t cfg_q;
  logic     push, full, pop, empty;
  rvp_vtx_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x     <= 12'd32;
      cfg_q.center_y     <= 12'd32;
      cfg_q.focal_length <= 16'd256;
      cfg_q.near_limit   <= 13'd41;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X:     cfg_q.center_x     <= cfg_data_i[11:0];
        CFG_CENTER_Y:     cfg_q.center_y     <= cfg_data_i[11:0];
        CFG_FOCAL_LENGTH: cfg_q.focal_length <= cfg_data_i;
        CFG_NEAR_LIMIT:   cfg_q.near_limit   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  rvp_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .near_limit_i (cfg_q.near_limit),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  rvp_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  rvp_back u_back (
    .clk_i,
    .rst_ni,
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .empty_i     (empty),
    .cfg_i       (cfg_q),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

// ===== design/rvp_checker.sv =====
module rvp_checker import rvp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input rvp_in_t     in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input rvp_out_t    out_data_o,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [15:0] cfg_data_i
);

  logic [7:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 8'd0)
    else $error("result word without a vertex in flight");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 8'd0 |-> in_ready_o)
    else $error("empty block refuses a vertex");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind rotate_and_project_vertex rvp_checker u_rvp_checker (.*);
